// ----- hw/rtl/hfs_pkg.sv -----
package hfs_pkg;

  // map geometry
  localparam int unsigned MAP_DEPTH  = 1024;
  localparam int unsigned OWNER_BITS = 4;
  localparam int unsigned IDX_W      = $clog2(MAP_DEPTH);
  localparam int unsigned LEN_W      = $clog2(MAP_DEPTH + 1);

  // field widths
  localparam int unsigned MODE_W = 3;
  localparam int unsigned OFFS_W = 10;
  localparam int unsigned OWN_W  = 4;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned NF_W   = 11;
  localparam int unsigned CFG_W  = 16;

  // common width for length and size compares
  localparam int unsigned CMP_W = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
  localparam int unsigned SUM_W = CMP_W + 1;

  // register indexes
  localparam logic REG_AREA_START = 1'b0;
  localparam logic REG_AREA_SIZE  = 1'b1;

  localparam logic [SIZE_W-1:0] AREA_SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 3'd0,
    MODE_FIRST = 3'd1,
    MODE_NEXT  = 3'd2,
    MODE_WORST = 3'd3,
    MODE_BEST  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_NF,
    ST_RETRY
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic pass_start;
    logic from_nf;
    logic nf_update;
    logic load_result;
    logic load_zero;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic pass_end;
    logic pass_hit;
  } ctrl_status_t;

endpackage

// ----- hw/rtl/hfs_ctrl.sv -----
module hfs_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  logic [hfs_pkg::MODE_W-1:0]           mode_i,
  input  hfs_pkg::ctrl_status_t                status_i,
  output hfs_pkg::ctrl_cmd_t                   cmd_o,
  output logic                                 busy
);

  hfs_pkg::ctrl_state_e state_q, state_d;
  logic                 is_search;

  assign is_search = (mode_i == hfs_pkg::MODE_FIRST) || (mode_i == hfs_pkg::MODE_NEXT) ||
                     (mode_i == hfs_pkg::MODE_WORST) || (mode_i == hfs_pkg::MODE_BEST);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      hfs_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = hfs_pkg::ST_IDLE;
        end
      end
      hfs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          if (is_search) begin
            cmd_o.pass_start = 1'b1;
            if (mode_i == hfs_pkg::MODE_NEXT) begin
              cmd_o.from_nf = 1'b1;
              state_d       = hfs_pkg::ST_SCAN_NF;
            end else begin
              state_d = hfs_pkg::ST_SCAN;
            end
          end else begin
            cmd_o.load_zero = 1'b1;
          end
        end
      end
      hfs_pkg::ST_SCAN_NF: begin
        if (status_i.pass_end) begin
          if (status_i.pass_hit) begin
            cmd_o.load_result = 1'b1;
            cmd_o.nf_update   = 1'b1;
            state_d           = hfs_pkg::ST_IDLE;
          end else begin
            // nothing past the pointer: fall back to first fit from zero
            cmd_o.pass_start = 1'b1;
            state_d          = hfs_pkg::ST_RETRY;
          end
        end
      end
      hfs_pkg::ST_SCAN, hfs_pkg::ST_RETRY: begin
        if (status_i.pass_end) begin
          cmd_o.load_result = 1'b1;
          state_d           = hfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/hfs_datapath.sv -----
module hfs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hfs_pkg::ctrl_cmd_t                   cmd_i,
  output hfs_pkg::ctrl_status_t                status_o,
  input  logic [hfs_pkg::MODE_W-1:0]           mode_i,
  input  logic [hfs_pkg::OFFS_W-1:0]           entry_offset_i,
  input  logic [hfs_pkg::OWN_W-1:0]            entry_owner_i,
  input  logic [hfs_pkg::SIZE_W-1:0]           request_size_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [hfs_pkg::CFG_W-1:0]            cfg_wdata_i,
  output logic                                 chunk_valid_o,
  output logic [hfs_pkg::ADDR_W-1:0]           chunk_address_o,
  output logic                                 chunk_found_o
);

  localparam int unsigned IDX_W = hfs_pkg::IDX_W;
  localparam int unsigned LEN_W = hfs_pkg::LEN_W;
  localparam int unsigned CMP_W = hfs_pkg::CMP_W;
  localparam int unsigned SUM_W = hfs_pkg::SUM_W;

  // configuration
  logic [hfs_pkg::ADDR_W-1:0] area_start_q;
  logic [hfs_pkg::SIZE_W-1:0] area_size_q;
  logic [hfs_pkg::NF_W-1:0]   nf_q, nf_d;

  // item latched at accept
  logic [hfs_pkg::MODE_W-1:0] mode_q;
  logic [hfs_pkg::SIZE_W-1:0] size_q;

  // owner map
  logic [hfs_pkg::OWNER_BITS-1:0] mem [hfs_pkg::MAP_DEPTH];
  logic [hfs_pkg::OWNER_BITS-1:0] rd_data_q;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_wa;
  logic [hfs_pkg::OWNER_BITS-1:0] mem_wd;
  logic [IDX_W-1:0]               rd_addr;
  logic [IDX_W-1:0]               clr_q;

  // scan state
  logic             vld_q, vld_d;
  logic             empty_q, empty_d;
  logic [IDX_W-1:0] eval_idx_q, eval_idx_d;
  logic [LEN_W-1:0] run_len_q, run_len_d;
  logic [IDX_W-1:0] run_start_q, run_start_d;
  logic [LEN_W-1:0] best_len_q, best_len_d;
  logic [IDX_W-1:0] best_pos_q, best_pos_d;
  logic             best_found_q, best_found_d;

  // output registers
  logic                       chunk_valid_q;
  logic [hfs_pkg::ADDR_W-1:0] chunk_address_q;
  logic                       chunk_found_q;

  // combinational scan terms
  logic [CMP_W-1:0]           area_len;
  logic [CMP_W-1:0]           begin_off;
  logic                       begin_ok;
  logic [hfs_pkg::MODE_W-1:0] mode_sel;
  logic                       want_big_sel;
  logic                       extreme;
  logic                       want_big;
  logic                       is_free;
  logic                       is_last;
  logic [LEN_W-1:0]           cur_len;
  logic [IDX_W-1:0]           cur_start;
  logic [CMP_W-1:0]           need;
  logic                       ff_hit;
  logic                       run_end;
  logic                       better;
  logic                       take;
  logic                       stop;
  logic                       eval_hit;
  logic [IDX_W-1:0]           eval_pos;
  logic [SUM_W-1:0]           nf_sum;

  // searched length saturates at the map depth
  assign area_len = (CMP_W'(area_size_q) > CMP_W'(hfs_pkg::MAP_DEPTH)) ?
                    CMP_W'(hfs_pkg::MAP_DEPTH) : CMP_W'(area_size_q);

  assign begin_off    = cmd_i.from_nf ? CMP_W'(nf_q) : '0;
  assign begin_ok     = begin_off < area_len;
  assign mode_sel     = cmd_i.accept ? mode_i : mode_q;
  assign want_big_sel = (mode_sel == hfs_pkg::MODE_WORST);
  assign extreme      = (mode_q == hfs_pkg::MODE_WORST) || (mode_q == hfs_pkg::MODE_BEST);
  assign want_big     = (mode_q == hfs_pkg::MODE_WORST);

  // run tracking on the entry read last cycle
  assign is_free   = (rd_data_q == '0);
  assign is_last   = (CMP_W'(eval_idx_q) == (area_len - CMP_W'(1)));
  assign cur_len   = is_free ? LEN_W'(run_len_q + LEN_W'(1)) : run_len_q;
  assign cur_start = (is_free && (run_len_q == '0)) ? eval_idx_q : run_start_q;
  assign need      = (size_q == '0) ? CMP_W'(1) : CMP_W'(size_q);
  assign ff_hit    = is_free && (CMP_W'(cur_len) >= need);
  assign run_end   = is_free ? is_last : (run_len_q != '0);
  assign better    = want_big ? (cur_len >= best_len_q) : (cur_len <= best_len_q);
  assign take      = run_end && (CMP_W'(cur_len) >= CMP_W'(size_q)) && better;
  assign stop      = is_last || (!extreme && ff_hit);
  assign eval_hit  = extreme ? (best_found_q || take) : ff_hit;
  assign eval_pos  = (extreme && !take) ? best_pos_q : cur_start;

  assign status_o.clear_last = (clr_q == IDX_W'(hfs_pkg::MAP_DEPTH - 1));
  assign status_o.pass_end   = empty_q || (vld_q && stop);
  assign status_o.pass_hit   = vld_q && stop && eval_hit;

  // next-fit pointer moves to the end of the chosen block
  assign nf_sum = SUM_W'(eval_pos) + SUM_W'(size_q);
  assign nf_d   = cmd_i.nf_update ? nf_sum[hfs_pkg::NF_W-1:0] : nf_q;

  // map write and read ports
  assign mem_we = cmd_i.clear ||
                  (cmd_i.accept && (mode_i == hfs_pkg::MODE_WRITE) &&
                   (CMP_W'(entry_offset_i) < CMP_W'(hfs_pkg::MAP_DEPTH)));
  assign mem_wa = cmd_i.clear ? clr_q : IDX_W'(entry_offset_i);
  assign mem_wd = cmd_i.clear ? '0 : hfs_pkg::OWNER_BITS'(entry_owner_i);
  assign rd_addr = cmd_i.pass_start ? IDX_W'(begin_off) : IDX_W'(eval_idx_q + IDX_W'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  // scan next state
  always_comb begin
    vld_d        = vld_q && !stop;
    empty_d      = 1'b0;
    eval_idx_d   = (vld_q && !stop) ? IDX_W'(eval_idx_q + IDX_W'(1)) : eval_idx_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_pos_d   = best_pos_q;
    best_found_d = best_found_q;
    if (cmd_i.pass_start) begin
      vld_d        = begin_ok;
      empty_d      = !begin_ok;
      eval_idx_d   = IDX_W'(begin_off);
      run_len_d    = '0;
      best_found_d = 1'b0;
      best_len_d   = want_big_sel ? '0 : LEN_W'(area_len);
    end else if (vld_q) begin
      run_len_d   = is_free ? cur_len : '0;
      run_start_d = cur_start;
      if (take) begin
        best_len_d   = cur_len;
        best_pos_d   = cur_start;
        best_found_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_start_q  <= '0;
      area_size_q   <= hfs_pkg::AREA_SIZE_RESET;
      nf_q          <= '0;
      clr_q         <= '0;
      vld_q         <= 1'b0;
      empty_q       <= 1'b0;
      chunk_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hfs_pkg::REG_AREA_START: area_start_q <= cfg_wdata_i;
          hfs_pkg::REG_AREA_SIZE:  area_size_q  <= cfg_wdata_i[hfs_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      nf_q          <= nf_d;
      vld_q         <= vld_d;
      empty_q       <= empty_d;
      chunk_valid_q <= cmd_i.load_result || cmd_i.load_zero;
      if (cmd_i.clear) begin
        clr_q <= IDX_W'(clr_q + IDX_W'(1));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      size_q <= request_size_i;
    end
    eval_idx_q   <= eval_idx_d;
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_pos_q   <= best_pos_d;
    best_found_q <= best_found_d;
    if (cmd_i.load_result) begin
      chunk_found_q   <= status_o.pass_hit;
      chunk_address_q <= status_o.pass_hit ?
                         hfs_pkg::ADDR_W'(area_start_q + hfs_pkg::ADDR_W'(eval_pos)) : '0;
    end else if (cmd_i.load_zero) begin
      chunk_found_q   <= 1'b0;
      chunk_address_q <= '0;
    end
  end

  assign chunk_valid_o   = chunk_valid_q;
  assign chunk_address_o = chunk_address_q;
  assign chunk_found_o   = chunk_found_q;

  // a beat without a fit carries address zero
  a_miss_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chunk_valid_q && !chunk_found_q) |-> (chunk_address_q == '0))
    else $error("miss beat with non-zero address");

  // a finished pass is followed by a result beat or a fresh pass
  a_pass_followup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.pass_end |=> (chunk_valid_q || vld_q || empty_q))
    else $error("pass ended with no result and no retry");

  // no scan runs while the map is being cleared
  a_no_scan_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> (!vld_q && !empty_q))
    else $error("scan active during clearing pass");

endmodule

// ----- hw/rtl/heap_fit_search.sv -----
// a write or an unused mode gives its result beat in the cycle after acceptance
// a first, worst or best fit scans the map one entry a cycle over the single read port
// next fit may scan twice (pointer pass, then from zero)
// busy is low in the cycle the beat is shown; results cannot be stalled by the receiver
// reset: busy stays high for a clearing pass that frees all MAP_DEPTH (1024) map entries
module heap_fit_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [hfs_pkg::MODE_W-1:0]           mode_i,
  input  logic [hfs_pkg::OFFS_W-1:0]           entry_offset_i,
  input  logic [hfs_pkg::OWN_W-1:0]            entry_owner_i,
  input  logic [hfs_pkg::SIZE_W-1:0]           request_size_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [hfs_pkg::CFG_W-1:0]            cfg_wdata_i,
  output logic                                 chunk_valid_o,
  output logic [hfs_pkg::ADDR_W-1:0]           chunk_address_o,
  output logic                                 chunk_found_o
);

  hfs_pkg::ctrl_cmd_t    cmd;
  hfs_pkg::ctrl_status_t status;

  // sequencing
  hfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // owner map, scan and result registers
  hfs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_i),
    .entry_offset_i  (entry_offset_i),
    .entry_owner_i   (entry_owner_i),
    .request_size_i  (request_size_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .chunk_valid_o   (chunk_valid_o),
    .chunk_address_o (chunk_address_o),
    .chunk_found_o   (chunk_found_o)
  );

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfs_pkg::*;

  // unused mode codes, answered with an all-zero beat
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 2 * MAP_DEPTH + 64;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              found;
  } chunk_t;

  // mirror of the allocation map, predicts one chunk beat per accepted item
  class heap_mirror;
    logic [OWNER_BITS-1:0] owners [MAP_DEPTH];
    logic [NF_W-1:0]       nf_ptr;
    logic [ADDR_W-1:0]     area_base;
    logic [SIZE_W-1:0]     area_len;
    chunk_t                due_chunks [$];

    function new();
      foreach (owners[k]) owners[k] = '0;
      nf_ptr    = '0;
      area_base = '0;
      area_len  = AREA_SIZE_RESET;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_AREA_START) area_base = data;
      else area_len = data[SIZE_W-1:0];
    endfunction

    // searched length, saturated at the map depth
    function int unsigned span();
      return (area_len > MAP_DEPTH) ? MAP_DEPTH : int'(area_len);
    endfunction

    // lowest free run from 'from' holding at least 'size' entries
    function bit scan_from(int unsigned from, int unsigned size, output int unsigned at);
      int unsigned n    = span();
      int unsigned need = (size == 0) ? 1 : size;
      int unsigned i    = from;
      int unsigned s;
      at = 0;
      while (i < n) begin
        if (owners[i] != '0) begin
          i++;
        end else begin
          s = i;
          while (i < n && owners[i] == '0) i++;
          if (i - s >= need) begin
            at = s;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // widest or narrowest fitting run, the later run taking a tie
    function bit scan_extreme(int unsigned size, bit widest, output int unsigned at);
      int unsigned n   = span();
      int unsigned top = widest ? 0 : n;
      int unsigned i   = 0;
      int unsigned s;
      int unsigned len;
      bit hit = 1'b0;
      at = 0;
      while (i < n) begin
        if (owners[i] != '0) begin
          i++;
        end else begin
          s = i;
          while (i < n && owners[i] == '0) i++;
          len = i - s;
          if (len >= size && (widest ? (len >= top) : (len <= top))) begin
            top = len;
            at  = s;
            hit = 1'b1;
          end
        end
      end
      return hit;
    endfunction

    function void take_item(logic [MODE_W-1:0] mode, logic [OFFS_W-1:0] off,
                            logic [OWN_W-1:0] own, logic [SIZE_W-1:0] size);
      chunk_t      exp;
      int unsigned at;
      bit          hit;
      at  = 0;
      hit = 1'b0;
      case (mode)
        MODE_WRITE: begin
          if (off < MAP_DEPTH) owners[off] = own[OWNER_BITS-1:0];
        end
        MODE_FIRST: hit = scan_from(0, size, at);
        MODE_NEXT: begin
          hit = scan_from(nf_ptr, size, at);
          if (hit) nf_ptr = NF_W'(at + size);
          else hit = scan_from(0, size, at);
        end
        MODE_WORST: hit = scan_extreme(size, 1'b1, at);
        MODE_BEST:  hit = scan_extreme(size, 1'b0, at);
        default: ;
      endcase
      exp.found = hit;
      exp.addr  = hit ? ADDR_W'(area_base + at) : '0;
      due_chunks.push_back(exp);
    endfunction

    function bit match_beat(logic [ADDR_W-1:0] addr, logic found, output string why);
      chunk_t exp;
      why = "";
      if (due_chunks.size() == 0) begin
        why = $sformatf("unexpected beat addr %h found %b", addr, found);
        return 1'b0;
      end
      exp = due_chunks.pop_front();
      if (addr !== exp.addr)
        why = $sformatf("chunk_address %h, want %h; ", addr, exp.addr);
      if (found !== exp.found)
        why = {why, $sformatf("chunk_found %b, want %b", found, exp.found)};
      return why == "";
    endfunction

    function int unsigned outstanding();
      return due_chunks.size();
    endfunction

    function void discard();
      due_chunks.delete();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  mode_i         = '0;
  logic [OFFS_W-1:0]  entry_offset_i = '0;
  logic [OWN_W-1:0]   entry_owner_i  = '0;
  logic [SIZE_W-1:0]  request_size_i = '0;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_idx_i      = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i    = '0;
  logic               chunk_valid_o;
  logic [ADDR_W-1:0]  chunk_address_o;
  logic               chunk_found_o;

  heap_mirror  mirror = new();
  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;

  heap_fit_search uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .entry_offset_i  (entry_offset_i),
    .entry_owner_i   (entry_owner_i),
    .request_size_i  (request_size_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .chunk_valid_o   (chunk_valid_o),
    .chunk_address_o (chunk_address_o),
    .chunk_found_o   (chunk_found_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // result beats, checked in order against the mirror
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && chunk_valid_o === 1'b1) begin
      if (!mirror.match_beat(chunk_address_o, chunk_found_o, why)) report(why);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [OFFS_W-1:0] off,
                           input logic [OWN_W-1:0] own, input logic [SIZE_W-1:0] size);
    start          <= 1'b1;
    mode_i         <= mode;
    entry_offset_i <= off;
    entry_owner_i  <= own;
    request_size_i <= size;
    do @(posedge clk_i); while (busy !== 1'b0);
    mirror.take_item(mode, off, own, size);
  endtask

  // random sender gap, mostly short
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 80);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic item(input logic [MODE_W-1:0] mode, input logic [OFFS_W-1:0] off,
                      input logic [OWN_W-1:0] own, input logic [SIZE_W-1:0] size);
    send_item(mode, off, own, size);
    idle_gap();
  endtask

  // stop sending and wait for every expected beat
  task automatic drain();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while ((mirror.outstanding() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (mirror.outstanding() != 0) begin
      report($sformatf("%0d expected beats never came", mirror.outstanding()));
      mirror.discard();
    end
  endtask

  // both registers, written back to back while idle
  task automatic set_area(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] len);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_AREA_START;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    mirror.write_reg(REG_AREA_START, base);
    cfg_idx_i   <= REG_AREA_SIZE;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    mirror.write_reg(REG_AREA_SIZE, len);
    cfg_we_i    <= 1'b0;
  endtask

  // random traffic: runs of owner writes, searches, the odd unused mode
  task automatic run_phase(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] len,
                           input int unsigned count);
    int unsigned lim;
    int unsigned done;
    int unsigned r;
    int unsigned run;
    int unsigned top;
    bit          paused;
    logic [OFFS_W-1:0] off;
    logic [OWN_W-1:0]  own;
    logic [SIZE_W-1:0] size;
    logic [MODE_W-1:0] mode;
    set_area(base, len);
    gaps_on = ($urandom_range(0, 3) != 0);
    lim    = mirror.span();
    if (lim == 0) lim = 1;
    done   = 0;
    paused = 1'b0;
    while (done < count) begin
      if (!paused && done >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // allocate or free a short run of entries
        off = ($urandom_range(0, 99) < 85) ? OFFS_W'($urandom_range(0, lim - 1))
                                            : OFFS_W'($urandom_range(0, MAP_DEPTH - 1));
        own = ($urandom_range(0, 99) < 40) ? '0 : OWN_W'($urandom_range(1, 15));
        run = $urandom_range(1, 6);
        for (int unsigned k = 0; k < run && done < count; k++) begin
          item(MODE_WRITE, off, own, SIZE_W'($urandom_range(0, 2047)));
          off = off + 1'b1;
          done++;
        end
      end else begin
        r   = $urandom_range(0, 99);
        top = (lim / 4 > 1) ? lim / 4 : 1;
        if (r < 70) size = SIZE_W'($urandom_range(0, top));
        else if (r < 90) size = SIZE_W'($urandom_range(0, lim));
        else size = SIZE_W'($urandom_range(0, 2047));
        mode = ($urandom_range(0, 99) < 90) ? MODE_W'($urandom_range(MODE_FIRST, MODE_BEST))
                                            : MODE_W'($urandom_range(MODE_UNUSED_LO,
                                                                     MODE_UNUSED_HI));
        item(mode, OFFS_W'($urandom_range(0, MAP_DEPTH - 1)), OWN_W'($urandom_range(0, 15)),
             size);
        done++;
      end
    end
  endtask

  // run limit
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);

    // directed part on the reset area: empty map first
    item(MODE_FIRST, '0, '0, 11'd0);
    item(MODE_FIRST, 10'h3FF, 4'hF, 11'd1024);
    item(MODE_NEXT, '0, '0, 11'd1025);
    item(MODE_WORST, '0, '0, 11'h7FF);
    item(MODE_WRITE, 10'h000, 4'hF, 11'h7FF);
    item(MODE_WRITE, 10'h3FF, 4'h1, 11'd0);
    item(MODE_WRITE, 10'h200, 4'h8, 11'd0);
    item(MODE_BEST, '0, '0, 11'd1);
    item(MODE_WORST, '0, '0, 11'd1);
    item(MODE_WRITE, 10'd5, 4'h3, 11'd0);
    item(MODE_WRITE, 10'd10, 4'h2, 11'd0);
    // two equal short runs, the later one wins
    item(MODE_BEST, '0, '0, 11'd2);
    item(MODE_WORST, '0, '0, 11'd510);
    // next fit walks forward, then finds nothing anywhere
    item(MODE_NEXT, '0, '0, 11'd3);
    item(MODE_NEXT, '0, '0, 11'd3);
    item(MODE_NEXT, '0, '0, 11'd600);
    item(MODE_NEXT, '0, '0, 11'd0);
    item(MODE_WRITE, 10'h200, 4'h0, 11'd0);
    item(MODE_NEXT, '0, '0, 11'd1000);
    item(MODE_UNUSED_HI, 10'h3FF, 4'hF, 11'h7FF);
    item(MODE_UNUSED_LO, 10'h155, 4'hA, 11'h2AA);
    item(MODE_FIRST, '0, '0, 11'd1013);
    item(MODE_WORST, '0, '0, 11'd0);

    // random phases over several area settings
    run_phase(16'h0000, 16'd100, 65);
    run_phase(16'h0000, 16'd64, 100);
    run_phase(16'hFFF0, 16'd40, 80);
    run_phase(16'h0000, 16'd0, 15);
    run_phase(16'hFFFF, 16'd1, 40);
    run_phase(CFG_W'($urandom_range(0, 65535)), 16'd128, 80);
    run_phase(16'h1234, 16'hF820, 60);
    run_phase(16'hA5A5, 16'h07FF, 20);
    run_phase(16'h0000, 16'd1024, 20);
    run_phase(CFG_W'($urandom_range(0, 65535)), 16'd9, 70);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hfs_pkg.sv
hw/rtl/hfs_ctrl.sv
hw/rtl/hfs_datapath.sv
hw/rtl/heap_fit_search.sv
bench/tb.sv
